// ===== rtl/tahf_pkg.sv =====
// shared constants, cordic angle table and rounding helpers for the tilt and heading block
package tahf_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;

    // guard scaling of samples and headroom for gain and pre-rotation
    localparam int GUARD_BITS = 8;
    localparam int HEAD_BITS  = 3;

    // angle accumulator, 1/256 centidegree
    localparam int AW = 24;

    localparam logic signed [AW-1:0] QUARTER_TURN = AW'(2304000);
    localparam logic [16:0]          INV_GAIN     = 17'd39797;

    localparam logic signed [15:0] DECL_RESET = -16'sd858;

    localparam logic signed [17:0] LIM_HALF    = 18'sd18000;
    localparam logic signed [17:0] LIM_QUARTER = 18'sd9000;
    localparam logic signed [17:0] FULL_TURN   = 18'sd36000;

    localparam logic REQ_ACCEL = 1'b0;
    localparam logic REQ_MAG   = 1'b1;

    function automatic logic signed [AW-1:0] atan_tab(input int idx);
        logic signed [AW-1:0] v;
        case (idx)
            0:       v = AW'(1152000);
            1:       v = AW'(680065);
            2:       v = AW'(359328);
            3:       v = AW'(182400);
            4:       v = AW'(91554);
            5:       v = AW'(45822);
            6:       v = AW'(22916);
            7:       v = AW'(11459);
            8:       v = AW'(5730);
            9:       v = AW'(2865);
            10:      v = AW'(1432);
            11:      v = AW'(716);
            12:      v = AW'(358);
            13:      v = AW'(179);
            14:      v = AW'(90);
            15:      v = AW'(45);
            16:      v = AW'(22);
            17:      v = AW'(11);
            18:      v = AW'(6);
            19:      v = AW'(3);
            20:      v = AW'(1);
            21:      v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // half away from zero, 1/256 centidegree to centidegree
    function automatic logic signed [17:0] round_cdeg(input logic signed [AW-1:0] v);
        logic [AW-1:0] mag;
        logic [AW-1:0] q;
        logic signed [17:0] r;
        mag = v[AW-1] ? AW'(-v) : AW'(v);
        q   = (mag + AW'(128)) >> 8;
        r   = v[AW-1] ? -$signed(18'(q)) : $signed(18'(q));
        return r;
    endfunction

    function automatic logic signed [17:0] clamp_sym(input logic signed [17:0] v,
                                                     input logic signed [17:0] lim);
        logic signed [17:0] r;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/tahf_cordic_cell.sv =====
// one vectoring cordic iteration with its pipeline register and sideband
module tahf_cordic_cell #(
    parameter int DW    = 27,
    parameter int SBW   = 8,
    parameter int STAGE = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [DW-1:0]        i_x,
    input  logic signed [DW-1:0]        i_y,
    input  logic signed [tahf_pkg::AW-1:0] i_z,
    input  logic [SBW-1:0]              i_sb,
    output logic                        o_valid,
    output logic signed [DW-1:0]        o_x,
    output logic signed [DW-1:0]        o_y,
    output logic signed [tahf_pkg::AW-1:0] o_z,
    output logic [SBW-1:0]              o_sb
);
    import tahf_pkg::*;

    logic                 r_valid;
    logic signed [DW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic [SBW-1:0]       r_sb;
    logic signed [DW-1:0] n_x, n_y;
    logic signed [AW-1:0] n_z;
    logic signed [DW-1:0] xs, ys;

    always_comb begin
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        if (!i_y[DW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + atan_tab(STAGE);
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - atan_tab(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_z  <= n_z;
            r_sb <= i_sb;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_sb    = r_sb;

endmodule

// ===== rtl/tilt_and_heading_from_accel_mag_top.sv =====
// roll, pitch and heading from accelerometer and magnetometer transactions
// transaction path: pre-rotation, chain a, magnitude, pre-rotation b, chain b, output
// throughput: one transaction per cycle, set by two unrolled chains of cordic cells
// the whole pipeline stalls only while the output register holds an untaken result
// reset (synchronous, active low): angles clear to zero, declination to -8.58 degrees
// the pipeline and output valid bits clear; no clearing pass
module tilt_and_heading_from_accel_mag_top #(
    parameter int SAMPLE_WIDTH  = tahf_pkg::SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = tahf_pkg::CORDIC_STAGES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_req_type,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_x,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_y,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_z,
    input  logic                    i_cfg_we,
    input  logic [15:0]             i_cfg_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [15:0]             o_roll_cdeg,
    output logic [14:0]             o_pitch_cdeg,
    output logic [16:0]             o_heading_cdeg
);
    import tahf_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int N   = CORDIC_STAGES;
    localparam int DW  = SW + GUARD_BITS + HEAD_BITS;
    localparam int SBA = SW + 3;
    localparam int SBB = AW + 4;

    logic en;

    // input scaling and pre-rotation
    logic signed [DW-1:0] sx_s, sy_s, sz_s, ax_in, ay_in;
    logic                 zero_a;
    logic                 r_a_v;
    logic signed [DW-1:0] r_a_x, r_a_y;
    logic signed [AW-1:0] r_a_z;
    logic [SBA-1:0]       r_a_sb;

    logic                 av  [0:N];
    logic signed [DW-1:0] ax  [0:N];
    logic signed [DW-1:0] ay  [0:N];
    logic signed [AW-1:0] az  [0:N];
    logic [SBA-1:0]       asb [0:N];

    logic                 bv  [0:N];
    logic signed [DW-1:0] bx  [0:N];
    logic signed [DW-1:0] by  [0:N];
    logic signed [AW-1:0] bz  [0:N];
    logic [SBB-1:0]       bsb [0:N];

    // magnitude scaling stage
    logic signed [DW+16:0] prod;
    logic signed [DW-1:0]  a_sx_s;
    logic signed [AW-1:0]  za_eff;
    logic                  a_zero;
    logic                  r_m_v;
    logic signed [DW-1:0]  r_m_mag, r_m_y;
    logic [SBB-1:0]        r_m_sb;

    // second pre-rotation stage
    logic                  r_b_v;
    logic signed [DW-1:0]  r_b_x, r_b_y;
    logic signed [AW-1:0]  r_b_z;
    logic [SBB-1:0]        r_b_sb;

    // final stage
    logic signed [15:0] r_decl;
    logic               r_out_v;
    logic signed [15:0] r_roll;
    logic signed [14:0] r_pitch;
    logic signed [16:0] r_heading;
    logic signed [17:0] f_roll, f_pitch, f_ang, f_h, f_hw;
    logic [SBB-1:0]     f_sb;

    assign en      = !r_out_v || i_ready;
    assign o_ready = en;

    always_comb begin
        sx_s = {{HEAD_BITS{i_sample_x[SW-1]}}, i_sample_x, {GUARD_BITS{1'b0}}};
        sy_s = {{HEAD_BITS{i_sample_y[SW-1]}}, i_sample_y, {GUARD_BITS{1'b0}}};
        sz_s = {{HEAD_BITS{i_sample_z[SW-1]}}, i_sample_z, {GUARD_BITS{1'b0}}};
        if (i_req_type == REQ_ACCEL) begin
            ax_in = sz_s;
            ay_in = sy_s;
        end else begin
            ax_in = sy_s;
            ay_in = sx_s;
        end
        zero_a = (ax_in == '0) && (ay_in == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_m_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_valid;
            r_m_v <= av[N];
            r_b_v <= r_m_v;
        end
    end

    // rotate by a quarter turn so that x is not negative
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!ay_in[DW-1]) begin
                r_a_x <= ay_in;
                r_a_y <= -ax_in;
                r_a_z <= QUARTER_TURN;
            end else begin
                r_a_x <= -ay_in;
                r_a_y <= ax_in;
                r_a_z <= -QUARTER_TURN;
            end
            r_a_sb <= {i_req_type, zero_a, (i_sample_y == '0), i_sample_x};
        end
    end

    assign av[0]  = r_a_v;
    assign ax[0]  = r_a_x;
    assign ay[0]  = r_a_y;
    assign az[0]  = r_a_z;
    assign asb[0] = r_a_sb;

    for (genvar g = 0; g < N; g++) begin : g_chain_a
        tahf_cordic_cell #(.DW(DW), .SBW(SBA), .STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (av[g]),
            .i_x     (ax[g]),
            .i_y     (ay[g]),
            .i_z     (az[g]),
            .i_sb    (asb[g]),
            .o_valid (av[g+1]),
            .o_x     (ax[g+1]),
            .o_y     (ay[g+1]),
            .o_z     (az[g+1]),
            .o_sb    (asb[g+1])
        );
    end

    always_comb begin
        a_zero = asb[N][SW+1];
        a_sx_s = {{HEAD_BITS{asb[N][SW-1]}}, asb[N][SW-1:0], {GUARD_BITS{1'b0}}};
        za_eff = a_zero ? '0 : az[N];
        prod   = $signed({{17{ax[N][DW-1]}}, ax[N]}) * $signed({{DW{1'b0}}, INV_GAIN});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_mag <= a_zero ? '0 : prod[DW+15:16];
            r_m_y   <= -a_sx_s;
            r_m_sb  <= {asb[N][SW+2], a_zero && (asb[N][SW-1:0] == '0),
                        asb[N][SW], asb[N][SW-1], za_eff};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r_m_y[DW-1]) begin
                r_b_x <= r_m_y;
                r_b_y <= -r_m_mag;
                r_b_z <= QUARTER_TURN;
            end else begin
                r_b_x <= -r_m_y;
                r_b_y <= r_m_mag;
                r_b_z <= -QUARTER_TURN;
            end
            r_b_sb <= r_m_sb;
        end
    end

    assign bv[0]  = r_b_v;
    assign bx[0]  = r_b_x;
    assign by[0]  = r_b_y;
    assign bz[0]  = r_b_z;
    assign bsb[0] = r_b_sb;

    for (genvar g = 0; g < N; g++) begin : g_chain_b
        tahf_cordic_cell #(.DW(DW), .SBW(SBB), .STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (bv[g]),
            .i_x     (bx[g]),
            .i_y     (by[g]),
            .i_z     (bz[g]),
            .i_sb    (bsb[g]),
            .o_valid (bv[g+1]),
            .o_x     (bx[g+1]),
            .o_y     (by[g+1]),
            .o_z     (bz[g+1]),
            .o_sb    (bsb[g+1])
        );
    end

    always_comb begin
        f_sb    = bsb[N];
        f_roll  = clamp_sym(round_cdeg(f_sb[AW-1:0]), LIM_HALF);
        f_pitch = f_sb[AW+2] ? '0 : clamp_sym(round_cdeg(bz[N]), LIM_QUARTER);
        // magnetometer y of zero gives a half turn or zero by the sign of x
        if (f_sb[AW+1]) begin
            f_ang = f_sb[AW] ? LIM_HALF : '0;
        end else begin
            f_ang = f_roll;
        end
        f_h = f_ang - 18'(r_decl);
        if (f_h > LIM_HALF) begin
            f_hw = f_h - FULL_TURN;
        end else if (f_h < -LIM_HALF) begin
            f_hw = f_h + FULL_TURN;
        end else if (f_h < 0) begin
            f_hw = f_h + FULL_TURN;
        end else begin
            f_hw = f_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl    <= DECL_RESET;
            r_out_v   <= 1'b0;
            r_roll    <= '0;
            r_pitch   <= '0;
            r_heading <= '0;
        end else begin
            if (i_cfg_we) begin
                r_decl <= i_cfg_data;
            end
            if (en) begin
                r_out_v <= bv[N];
                if (bv[N]) begin
                    if (f_sb[AW+3] == REQ_ACCEL) begin
                        r_roll  <= f_roll[15:0];
                        r_pitch <= f_pitch[14:0];
                    end else begin
                        r_heading <= f_hw[16:0];
                    end
                end
            end
        end
    end

    assign o_valid        = r_out_v;
    assign o_roll_cdeg    = r_roll;
    assign o_pitch_cdeg   = r_pitch;
    assign o_heading_cdeg = r_heading;

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_roll <= 16'sd18000) && (r_roll >= -16'sd18000))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pitch <= 15'sd9000) && (r_pitch >= -15'sd9000))
        else $error("pitch out of range");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_heading <= 17'sd36000) && (r_heading >= -17'sd36000))
        else $error("heading out of range");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |=> $stable(bv[N]) && $stable(r_a_v))
        else $error("pipeline moved while output stalled");

endmodule

// ===== test/tilt_and_heading_from_accel_mag_top_test.sv =====
// self-checking testbench for the tilt and heading block with its own cordic angle predictor
module tilt_and_heading_from_accel_mag_top_test;
    import tahf_pkg::*;

    typedef struct {
        logic [15:0] roll;
        logic [14:0] pitch;
        logic [16:0] heading;
    } t_angles;

    typedef struct {
        logic              req;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        bit                typed;
        t_angles           ang;
    } t_stim_row;

    localparam int LATENCY     = 2 * 16 + 4;
    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_req_type;
    logic [15:0] i_sample_x;
    logic [15:0] i_sample_y;
    logic [15:0] i_sample_z;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_roll_cdeg;
    logic [14:0] o_pitch_cdeg;
    logic [16:0] o_heading_cdeg;

    tilt_and_heading_from_accel_mag_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_sample_x     (i_sample_x),
        .i_sample_y     (i_sample_y),
        .i_sample_z     (i_sample_z),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_roll_cdeg    (o_roll_cdeg),
        .o_pitch_cdeg   (o_pitch_cdeg),
        .o_heading_cdeg (o_heading_cdeg)
    );

    // predictor state
    longint    roll_now;
    longint    pitch_now;
    longint    heading_now;
    longint    decl_now;
    t_angles   angles_due[$];
    t_stim_row rows[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  cycles;

    longint arctan_steps[24] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45,
        22, 11, 6, 3, 1, 1, 0, 0
    };

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, angles_due.size());
            $display("tilt_and_heading_from_accel_mag_top_test: errors");
            $finish;
        end
    end

    function automatic longint centideg(longint v);
        if (v >= 0) return (v + 128) / 256;
        return -((-v + 128) / 256);
    endfunction

    function automatic longint limit_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // vectoring cordic: angle of (x,y) in 1/256 centidegree, scaled magnitude out
    function automatic longint vector_atan(longint x, longint y, output longint mag);
        longint z;
        longint tx;
        if (x == 0 && y == 0) begin
            mag = 0;
            return 0;
        end
        if (y >= 0) begin
            tx = y; y = -x; z = 2304000;
        end else begin
            tx = -y; y = x; z = -2304000;
        end
        x = tx;
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                tx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arctan_steps[i];
            end else begin
                tx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arctan_steps[i];
            end
            x = tx;
        end
        mag = x;
        return z;
    endfunction

    function automatic t_angles update_attitude(logic req, logic signed [15:0] sx,
                                                logic signed [15:0] sy,
                                                logic signed [15:0] sz);
        longint  a;
        longint  m;
        longint  unused;
        longint  h;
        t_angles r;
        if (req == REQ_ACCEL) begin
            a = vector_atan(longint'(sz) * 256, longint'(sy) * 256, m);
            roll_now = limit_to(centideg(a), 18000);
            m = (m * 39797) >>> 16;
            a = vector_atan(m, -longint'(sx) * 256, unused);
            pitch_now = limit_to(centideg(a), 9000);
        end else begin
            if (sy == 0) begin
                h = (sx < 0) ? 18000 : 0;
            end else begin
                a = vector_atan(longint'(sy) * 256, longint'(sx) * 256, unused);
                h = limit_to(centideg(a), 18000);
            end
            h -= decl_now;
            if (h > 18000) h -= 36000;
            else if (h < -18000) h += 36000;
            else if (h < 0) h += 36000;
            heading_now = h;
        end
        r.roll    = roll_now[15:0];
        r.pitch   = pitch_now[14:0];
        r.heading = heading_now[16:0];
        return r;
    endfunction

    task automatic add_row(logic req, int x, int y, int z, bit typed = 0,
                           int roll = 0, int pitch = 0, int heading = 0);
        t_stim_row r;
        r.req = req; r.x = x[15:0]; r.y = y[15:0]; r.z = z[15:0];
        r.typed = typed;
        r.ang.roll = roll[15:0]; r.ang.pitch = pitch[14:0]; r.ang.heading = heading[16:0];
        rows.push_back(r);
    endtask

    // drives one transaction, holding payload until accepted
    task automatic send_sample(t_stim_row r);
        t_angles p;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid    = 1'b1;
        i_req_type = r.req;
        i_sample_x = r.x;
        i_sample_y = r.y;
        i_sample_z = r.z;
        do @(posedge i_clk); while (!o_ready);
        p = update_attitude(r.req, r.x, r.y, r.z);
        angles_due.push_back(r.typed ? r.ang : p);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_decl(logic signed [15:0] d);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = d;
        decl_now   = d;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    function automatic int pick_axis(int kind);
        int ends[5] = '{-32768, -1, 0, 1, 32767};
        case (kind)
            6: return $urandom_range(0, 127) - 64;
            8: return ends[$urandom_range(0, 4)];
            9: return 0;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic send_random(int n, bit hold_off);
        t_stim_row r;
        int kind;
        for (int k = 0; k < n; k++) begin
            kind    = $urandom_range(0, 9);
            r.req   = 1'($urandom_range(0, 1));
            r.x     = 16'(pick_axis(kind));
            r.y     = (kind == 7) ? 16'sd0 : 16'(pick_axis(kind));
            r.z     = 16'(pick_axis(kind));
            r.typed = 0;
            send_sample(r);
            // let the pipeline empty completely once mid-stream
            if (hold_off && k == n / 2) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                while (angles_due.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    // result checker
    always @(negedge i_clk) begin
        if (i_rst_n) i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_angles e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (angles_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                e = angles_due.pop_front();
                if (o_roll_cdeg !== e.roll || o_pitch_cdeg !== e.pitch ||
                    o_heading_cdeg !== e.heading) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: roll %0d/%0d pitch %0d/%0d heading %0d/%0d",
                                 $signed(e.roll), $signed(o_roll_cdeg),
                                 $signed(e.pitch), $signed(o_pitch_cdeg),
                                 $signed(e.heading), $signed(o_heading_cdeg));
                end
            end
        end
    end

    initial begin
        logic signed [15:0] decls[8];
        cycles = 0; mismatches = 0; results_seen = 0; items_sent = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_req_type = REQ_ACCEL;
        i_sample_x = '0; i_sample_y = '0; i_sample_z = '0;
        i_cfg_we = 1'b0; i_cfg_data = '0; i_ready = 1'b0;
        roll_now = 0; pitch_now = 0; heading_now = 0; decl_now = -858;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero vectors and heading with y zero under the reset declination
        add_row(REQ_ACCEL, 0, 0, 0, 1, 0, 0, 0);
        add_row(REQ_MAG, 0, 0, 0, 1, 0, 0, 858);
        add_row(REQ_MAG, -1, 0, 5, 1, 0, 0, -17142);
        add_row(REQ_MAG, 32767, 0, 0, 1, 0, 0, 858);
        add_row(REQ_ACCEL, -32768, -32768, -32768);
        add_row(REQ_ACCEL, 32767, 32767, 32767);
        add_row(REQ_ACCEL, 0, 0, -5);
        add_row(REQ_ACCEL, 0, 1, -32768);
        add_row(REQ_ACCEL, 0, -1, -32768);
        add_row(REQ_ACCEL, 32767, 0, 0);
        add_row(REQ_ACCEL, -32768, 0, 0);
        add_row(REQ_ACCEL, 0, 32767, 0);
        add_row(REQ_ACCEL, 0, -32768, 0);
        add_row(REQ_MAG, 32767, 32767, 0);
        add_row(REQ_MAG, -32768, -32768, 0);
        add_row(REQ_MAG, 0, 1, 0);
        add_row(REQ_MAG, 0, -1, 0);
        add_row(REQ_MAG, 1, -32768, 0);
        add_row(REQ_MAG, -1, -32768, 0);
        add_row(REQ_MAG, 100, 3, 0);
        foreach (rows[i]) send_sample(rows[i]);
        drain();

        decls = '{16'sd18000, -16'sd18000, 16'sd0, 16'sd32767, -16'sd32768,
                  16'(int'($urandom_range(0, 36000)) - 18000), 16'sd1, -16'sd858};
        for (int ph = 0; ph < 9; ph++) begin
            write_decl(decls[ph % 8]);
            case (ph / 3)
                0: begin send_idle_pct = 27; recv_idle_pct = 48; end
                1: begin send_idle_pct = 48; recv_idle_pct = 27; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            send_random(110, ph == 1);
            drain();
        end

        if (angles_due.size() != 0) mismatches += angles_due.size();
        $display("sent %0d samples (accel and mag, extremes and random) over 9 declination phases",
                 items_sent);
        $display("checked %0d results under mixed sender and receiver stalls, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("tilt_and_heading_from_accel_mag_top_test: clean");
        end else begin
            $display("tilt_and_heading_from_accel_mag_top_test: errors");
        end
        $finish;
    end

endmodule
